// ----- rtl/core/yags_pkg.sv -----
// ----------------------------------------------------------------------------
// yags_pkg
// Shared types, constants and counter helpers for the YAGS branch predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package yags_pkg;

    // Fixed widths of the request fields and of the word address.
    localparam int PC_W   = 64;
    localparam int HIST_W = 10;
    localparam int WORD_W = 32;

    // Default table geometry.
    localparam int CHOICE_INDEX_BITS_DEF    = 12;
    localparam int EXCEPTION_INDEX_BITS_DEF = 10;
    localparam int TAG_WIDTH_DEF            = 8;

    // Two-bit saturating counter encoding.
    localparam logic [1:0] CTR_SNT = 2'd0;
    localparam logic [1:0] CTR_WNT = 2'd1;
    localparam logic [1:0] CTR_WT  = 2'd2;
    localparam logic [1:0] CTR_ST  = 2'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    // Moves a counter one step toward the resolved outcome, saturating.
    function automatic logic [1:0] ctr_train(input logic [1:0] ctr, input logic up);
        logic [1:0] res;
        res = ctr;
        if (up) begin
            case (ctr)
                CTR_SNT: res = CTR_WNT;
                CTR_WNT: res = CTR_WT;
                CTR_WT:  res = CTR_ST;
                default: res = CTR_ST;
            endcase
        end else begin
            case (ctr)
                CTR_SNT: res = CTR_SNT;
                CTR_WNT: res = CTR_SNT;
                CTR_WT:  res = CTR_WNT;
                default: res = CTR_WT;
            endcase
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/yags_if.sv -----
// ----------------------------------------------------------------------------
// yags_req_if / yags_rsp_if
// Valid/ready channels carrying predictor requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface yags_req_if;
    import yags_pkg::*;

    logic                valid;
    logic                ready;
    logic                op;
    logic [PC_W-1:0]     pc;
    logic [HIST_W-1:0]   history;
    logic                taken;

    modport source (output valid, output op, output pc, output history, output taken,
                    input ready);
    modport sink   (input valid, input op, input pc, input history, input taken,
                    output ready);
endinterface

interface yags_rsp_if;
    logic valid;
    logic ready;
    logic predict_taken;
    logic cache_hit;

    modport source (output valid, output predict_taken, output cache_hit, input ready);
    modport sink   (input valid, input predict_taken, input cache_hit, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/yags_branch_predictor.sv -----
// ----------------------------------------------------------------------------
// yags_branch_predictor
// YAGS branch direction predictor with a choice table and two direction caches.
// ----------------------------------------------------------------------------
// After reset a clearing pass steps a counter through 2**max(CHOICE_INDEX_BITS,
// EXCEPTION_INDEX_BITS) values (4096 with the defaults), writing the reset
// values into all three tables while it accepts no request. Each request then
// takes two steps: when it is taken, the choice table and both direction
// caches are read into registered read data; in the lookup state the
// prediction is formed and the trained entries are written back. Requests
// are taken only in the idle state; the lookup holds until the response
// register is free or drained in that cycle. The response waits in its own
// register, so the request side keeps moving while a finished response is
// not yet taken. Each request yields exactly one response holding the
// prediction and the tag-hit flag as they stood before the training it caused.
// ----------------------------------------------------------------------------
`default_nettype none

module yags_branch_predictor #(
    parameter int CHOICE_INDEX_BITS    = yags_pkg::CHOICE_INDEX_BITS_DEF,
    parameter int EXCEPTION_INDEX_BITS = yags_pkg::EXCEPTION_INDEX_BITS_DEF,
    parameter int TAG_WIDTH            = yags_pkg::TAG_WIDTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    yags_req_if.sink    i_req,
    yags_rsp_if.source  o_rsp
);
    import yags_pkg::*;

    localparam int CIB      = CHOICE_INDEX_BITS;
    localparam int EIB      = EXCEPTION_INDEX_BITS;
    localparam int CLR_BITS = (CIB > EIB) ? CIB : EIB;
    localparam int ENTRY_W  = TAG_WIDTH + 2;

    // ------------------------------------------------------------------
    // Request decode. The word address is pc[33:2]; higher pc bits never
    // take part in indexing or tagging.
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] req_word;
    logic [WORD_W-1:0] req_mix;
    logic [CIB-1:0]    req_ci;
    logic [EIB-1:0]    req_ei;
    logic              req_xfer;

    assign req_word = i_req.pc[WORD_W+1:2];
    assign req_mix  = req_word ^ {{(WORD_W-HIST_W){1'b0}}, i_req.history};
    assign req_ci   = req_word[CIB-1:0];
    assign req_ei   = req_mix[EIB-1:0];
    assign req_xfer = i_req.valid && i_req.ready;

    // Registered request held for the lookup cycle.
    logic                 r_op;
    logic                 r_taken;
    logic [CIB-1:0]       r_ci;
    logic [EIB-1:0]       r_ei;
    logic [TAG_WIDTH-1:0] r_tag;

    always_ff @(posedge i_clk) begin
        if (req_xfer) begin
            r_op    <= i_req.op;
            r_taken <= i_req.taken;
            r_ci    <= req_ci;
            r_ei    <= req_ei;
            r_tag   <= req_word[TAG_WIDTH-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Control state machine.
    // ------------------------------------------------------------------
    t_state              r_state;
    t_state              n_state;
    logic [CLR_BITS-1:0] r_clr_cnt;
    logic                clr_last;
    logic                rsp_free;
    logic                lookup_go;
    logic                clearing;
    logic                rd_en;

    assign clr_last = (r_clr_cnt == {CLR_BITS{1'b1}});
    assign rsp_free = !o_rsp.valid || o_rsp.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:  if (clr_last)  n_state = ST_IDLE;
            ST_IDLE:   if (req_xfer)  n_state = ST_LOOKUP;
            ST_LOOKUP: if (rsp_free)  n_state = ST_IDLE;
            default:                  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        i_req.ready = 1'b0;
        lookup_go   = 1'b0;
        clearing    = 1'b0;
        case (r_state)
            ST_CLEAR:  clearing    = 1'b1;
            ST_IDLE:   i_req.ready = 1'b1;
            ST_LOOKUP: lookup_go   = rsp_free;
            default:   clearing    = 1'b0;
        endcase
    end

    assign rd_en = req_xfer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Lookup. Both caches are read on every request because the bias is
    // only known once the choice counter arrives; the bias then selects
    // which cache entry is consulted.
    // ------------------------------------------------------------------
    logic [1:0]           choice_rd;
    logic [ENTRY_W-1:0]   tk_rd;
    logic [ENTRY_W-1:0]   nt_rd;
    logic                 bias;
    logic [ENTRY_W-1:0]   entry;
    logic [TAG_WIDTH-1:0] entry_tag;
    logic [1:0]           entry_ctr;
    logic                 hit;
    logic                 pred;
    logic                 alloc_or_train;
    logic [1:0]           new_ctr;

    assign bias      = choice_rd[1];
    assign entry     = bias ? tk_rd : nt_rd;
    assign entry_tag = entry[ENTRY_W-1:2];
    assign entry_ctr = entry[1:0];
    assign hit       = (entry_tag == r_tag);
    assign pred      = hit ? entry_ctr[1] : bias;

    // On a hit the counter trains; on a miss that disagrees with the bias the
    // entry is claimed with a weak counter leaning against the bias.
    assign alloc_or_train = r_op && (hit || (r_taken != bias));
    assign new_ctr        = hit ? ctr_train(entry_ctr, r_taken) : (bias ? CTR_WNT : CTR_WT);

    // ------------------------------------------------------------------
    // Table write ports, shared between the clearing pass and write-back.
    // ------------------------------------------------------------------
    logic               choice_we;
    logic [CIB-1:0]     choice_waddr;
    logic [1:0]         choice_wdata;
    logic               tk_we;
    logic               nt_we;
    logic [EIB-1:0]     cache_waddr;
    logic [ENTRY_W-1:0] tk_wdata;
    logic [ENTRY_W-1:0] nt_wdata;

    always_comb begin
        if (clearing) begin
            choice_we    = 1'b1;
            choice_waddr = r_clr_cnt[CIB-1:0];
            choice_wdata = CTR_WT;
            tk_we        = 1'b1;
            nt_we        = 1'b1;
            cache_waddr  = r_clr_cnt[EIB-1:0];
            tk_wdata     = {{TAG_WIDTH{1'b0}}, CTR_ST};
            nt_wdata     = {{TAG_WIDTH{1'b0}}, CTR_SNT};
        end else begin
            choice_we    = lookup_go && r_op;
            choice_waddr = r_ci;
            choice_wdata = ctr_train(choice_rd, r_taken);
            tk_we        = lookup_go && alloc_or_train && bias;
            nt_we        = lookup_go && alloc_or_train && !bias;
            cache_waddr  = r_ei;
            tk_wdata     = {r_tag, new_ctr};
            nt_wdata     = {r_tag, new_ctr};
        end
    end

    yags_ram #(.WIDTH(2), .DEPTH(2 ** CIB)) u_choice (
        .i_clk   (i_clk),
        .i_we    (choice_we),
        .i_waddr (choice_waddr),
        .i_wdata (choice_wdata),
        .i_re    (rd_en),
        .i_raddr (req_ci),
        .o_rdata (choice_rd)
    );

    yags_ram #(.WIDTH(ENTRY_W), .DEPTH(2 ** EIB)) u_taken_cache (
        .i_clk   (i_clk),
        .i_we    (tk_we),
        .i_waddr (cache_waddr),
        .i_wdata (tk_wdata),
        .i_re    (rd_en),
        .i_raddr (req_ei),
        .o_rdata (tk_rd)
    );

    yags_ram #(.WIDTH(ENTRY_W), .DEPTH(2 ** EIB)) u_not_taken_cache (
        .i_clk   (i_clk),
        .i_we    (nt_we),
        .i_waddr (cache_waddr),
        .i_wdata (nt_wdata),
        .i_re    (rd_en),
        .i_raddr (req_ei),
        .o_rdata (nt_rd)
    );

    // ------------------------------------------------------------------
    // Response register. It is loaded in the lookup cycle and holds until
    // the consumer completes the transfer.
    // ------------------------------------------------------------------
    logic r_rsp_valid;
    logic r_rsp_pred;
    logic r_rsp_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (lookup_go) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lookup_go) begin
            r_rsp_pred <= pred;
            r_rsp_hit  <= hit;
        end
    end

    assign o_rsp.valid         = r_rsp_valid;
    assign o_rsp.predict_taken = r_rsp_pred;
    assign o_rsp.cache_hit     = r_rsp_hit;

`ifndef NO_ASSERTIONS
    // Outside the clearing pass, only the consulted cache may be written.
    a_one_cache_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !clearing |-> !(tk_we && nt_we))
        else $error("both direction caches written during lookup");

    // A request transfer always leads into a lookup with fresh read data.
    a_xfer_to_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_xfer |=> (r_state == ST_LOOKUP))
        else $error("request transfer did not enter lookup");

    // A new response only appears right after a lookup completes.
    a_rsp_from_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rsp_valid) |-> ($past(r_state) == ST_LOOKUP))
        else $error("response raised without a lookup");

    // Table training never overlaps a request transfer.
    a_no_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_xfer |-> !(choice_we || tk_we || nt_we))
        else $error("table write overlaps a request read");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/yags_ram.sv -----
// ----------------------------------------------------------------------------
// yags_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module yags_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
